FILE: design/bmg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmg_pkg: shared constants and types for the Gaussian sample unit
// Fixed-point constants of the log, root and cosine pipelines.
// ----------------------------------------------------------------------------
package bmg_pkg;

  localparam int unsigned UniformBitsDef = 16;
  localparam int unsigned LogFracBits    = 24;
  localparam int unsigned CfgIdxW        = 1;
  localparam int unsigned CfgDataW       = 16;
  localparam int unsigned OutW           = 24;

  localparam logic [CfgIdxW-1:0] CfgMeanOffset = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgStdScale   = 1'b1;

  localparam logic [32:0] TwoLn2Q32   = 33'd5954088944;
  localparam logic [31:0] HalfPiQ30   = 32'd1686629713;
  localparam logic signed [33:0] Q30One = 34'sd1073741824;

  // Horner divisors of the cosine series, applied in this order.
  localparam int CosSteps = 7;
  localparam logic [7:0] CosDiv [CosSteps] = '{8'd182, 8'd132, 8'd90, 8'd56,
                                               8'd30, 8'd12, 8'd2};

  localparam logic signed [OutW-1:0] OutMax = 24'sh7FFFFF;
  localparam logic signed [OutW-1:0] OutMin = -24'sh800000;

endpackage

FILE: design/bmg_log2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmg_log2: pipelined log2 of a nonzero InW-bit integer
// One stage for normalization, then one squaring step per fraction bit.
// One word per cycle.
// ----------------------------------------------------------------------------
module bmg_log2
  import bmg_pkg::*;
#(
  parameter int unsigned InW = 17,
  parameter int unsigned TagW = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [InW-1:0]         x_i,
  input  logic [TagW-1:0]        tag_i,
  output logic                   valid_o,
  output logic [LogFracBits+5:0] log_o,
  output logic [TagW-1:0]        tag_o
);

  localparam int unsigned NS = LogFracBits + 1;

  logic [NS-1:0]     vld_q;
  logic [31:0]       m_q   [NS];
  logic [5:0]        n_q   [NS];
  logic [LogFracBits-1:0] fr_q [NS];
  logic [TagW-1:0]   tg_q  [NS];

  logic [5:0]  n_d;
  logic [63:0] xw;
  logic [31:0] m_d;

  always_comb begin
    n_d = '0;
    for (int i = 0; i < InW; i++) begin
      if (x_i[i]) begin
        n_d = 6'(i);
      end
    end
    xw = 64'(x_i);
    if (n_d <= 6'd30) begin
      m_d = 32'(xw << (6'd30 - n_d));
    end else begin
      m_d = 32'(xw >> (n_d - 6'd30));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    m_q[0]  <= m_d;
    n_q[0]  <= n_d;
    fr_q[0] <= '0;
    tg_q[0] <= tag_i;
  end

  for (genvar s = 1; s < NS; s++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] ms;
    assign sq = 64'(m_q[s-1]) * 64'(m_q[s-1]);
    assign ms = 33'(sq >> 30);
    always_ff @(posedge clk_i) begin
      n_q[s]  <= n_q[s-1];
      tg_q[s] <= tg_q[s-1];
      if (ms[32] | ms[31]) begin
        m_q[s]  <= 32'(ms >> 1);
        fr_q[s] <= {fr_q[s-1][LogFracBits-2:0], 1'b1};
      end else begin
        m_q[s]  <= ms[31:0];
        fr_q[s] <= {fr_q[s-1][LogFracBits-2:0], 1'b0};
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign log_o   = {n_q[NS-1], fr_q[NS-1]};
  assign tag_o   = tg_q[NS-1];

endmodule

FILE: design/bmg_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmg_isqrt: pipelined integer square root
// Restoring digit recurrence, one result bit per stage.
// ----------------------------------------------------------------------------
module bmg_isqrt
  import bmg_pkg::*;
#(
  parameter int unsigned VW = 56,
  parameter int unsigned TagW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [VW-1:0]   v_i,
  input  logic [TagW-1:0] tag_i,
  output logic            valid_o,
  output logic [VW/2-1:0] root_o,
  output logic [TagW-1:0] tag_o
);

  localparam int unsigned NB = VW / 2;

  logic [NB-1:0]   vld_q;
  logic [VW-1:0]   rem_q [NB];
  logic [NB-1:0]   res_q [NB];
  logic [VW-1:0]   val_q [NB];
  logic [TagW-1:0] tg_q  [NB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NB-2:0], valid_i};
    end
  end

  for (genvar s = 0; s < NB; s++) begin : g_bit
    localparam int unsigned B = NB - 1 - s;
    logic [VW-1:0]   rem_in;
    logic [NB-1:0]   res_in;
    logic [VW-1:0]   val_in;
    logic [TagW-1:0] tg_in;
    logic [VW+1:0]   rem_n;
    logic [VW+1:0]   trial;
    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign res_in = '0;
      assign val_in = v_i;
      assign tg_in  = tag_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign res_in = res_q[s-1];
      assign val_in = val_q[s-1];
      assign tg_in  = tg_q[s-1];
    end
    assign rem_n = {rem_in, val_in[2*B+1], val_in[2*B]};
    assign trial = (VW+2)'({res_in, 2'b01});
    always_ff @(posedge clk_i) begin
      val_q[s] <= val_in;
      tg_q[s]  <= tg_in;
      if (rem_n >= trial) begin
        rem_q[s] <= VW'(rem_n - trial);
        res_q[s] <= {res_in[NB-2:0], 1'b1};
      end else begin
        rem_q[s] <= VW'(rem_n);
        res_q[s] <= {res_in[NB-2:0], 1'b0};
      end
    end
  end

  assign valid_o = vld_q[NB-1];
  assign root_o  = res_q[NB-1];
  assign tag_o   = tg_q[NB-1];

endmodule

FILE: design/box_muller_gaussian_sample_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_muller_gaussian_sample_unit: Box-Muller normal sample generator
// One Gaussian word per uniform pair: mean + std * sqrt(-2 ln u1) cos(2 pi u2).
// ----------------------------------------------------------------------------
// Usage:
//   Drive uniform_radius_i / uniform_angle_i and pulse start. busy is
//   tied low: a new pair is taken on every cycle that start is high, so
//   the unit sustains one word per clock. Each pair yields exactly one
//   result word on gaussian_sample_o, flagged by a one-cycle done_o strobe.
//   The pipeline holds 1 normalize + 24 log squaring stages, 2 for the
//   ln2 product, 28 square-root stages (root of a 56-bit radicand), and
//   5 output stages (product, scale, round/saturate). The cosine of the
//   angle runs alongside the log/root chain as a Horner series, two
//   stages per term, and waits in a delay line.
//   Configuration: cfg_we_i / cfg_idx_i / cfg_wdata_i write mean_offset
//   (index 0, signed Q8.8) and std_scale (index 1, unsigned Q8.8).
//   Reset clears all valid bits and sets mean 0, std 1.0. There is no
//   output backpressure; results are delivered in order, never dropped.
// ----------------------------------------------------------------------------
module box_muller_gaussian_sample_unit
  import bmg_pkg::*;
#(
  parameter int unsigned UNIFORM_BITS = UniformBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [UNIFORM_BITS-1:0]    uniform_radius_i,
  input  logic [UNIFORM_BITS-1:0]    uniform_angle_i,
  output logic                       done_o,
  output logic signed [OutW-1:0]     gaussian_sample_o,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_idx_i,
  input  logic [CfgDataW-1:0]        cfg_wdata_i
);

  localparam int unsigned LogW   = LogFracBits + 6;
  localparam int unsigned SqW    = 56;     // radicand width, r < 2^32
  localparam int unsigned RootW  = SqW / 2;
  // cycles from entry to the root output; cosine is delayed to match
  localparam int unsigned CosLat = 3 + 2 * CosSteps + 1;
  localparam int unsigned RootLat = LogFracBits + 1 + 2 + RootW;
  localparam int unsigned DlyN   = RootLat - CosLat;

  logic signed [15:0] mean_q;
  logic [15:0]        std_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q <= '0;
      std_q  <= 16'd256;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMeanOffset: mean_q <= cfg_wdata_i;
        CfgStdScale:   std_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic acc;
  assign acc = start & ~busy;

  // ---------------- radius: log2, scale by 2 ln2, square root ----------
  logic            lg_vld;
  logic [LogW-1:0] lg;
  logic [0:0]      lg_tag;

  bmg_log2 #(.InW(UNIFORM_BITS + 1), .TagW(1)) u_log (
    .clk_i, .rst_ni,
    .valid_i (acc),
    .x_i     ((UNIFORM_BITS+1)'(uniform_radius_i) + 1'b1),
    .tag_i   (1'b0),
    .valid_o (lg_vld),
    .log_o   (lg),
    .tag_o   (lg_tag)
  );

  logic        rt_vld_q, rp_vld_q;
  logic [LogW-1:0] t_q;
  logic [63:0] rprod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_vld_q <= 1'b0;
      rp_vld_q <= 1'b0;
    end else begin
      rt_vld_q <= lg_vld & ~lg_tag[0];
      rp_vld_q <= rt_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q     <= LogW'((LogW)'(UNIFORM_BITS) << LogFracBits) - lg;
    rprod_q <= 64'(t_q) * 64'(TwoLn2Q32);
  end

  logic [31:0]      r_w;
  logic [SqW-1:0]   rad;
  assign r_w = rprod_q[63:32];
  assign rad = SqW'({r_w, {LogFracBits{1'b0}}});

  logic             sq_vld;
  logic [RootW-1:0] root;
  logic [0:0]       sq_tag;

  bmg_isqrt #(.VW(SqW), .TagW(1)) u_sqrt (
    .clk_i, .rst_ni,
    .valid_i (rp_vld_q),
    .v_i     (rad),
    .tag_i   (1'b0),
    .valid_o (sq_vld),
    .root_o  (root),
    .tag_o   (sq_tag)
  );

  // ---------------- angle: quadrant fold and Horner cosine -------------
  logic [31:0] ph;
  logic [29:0] xlo;
  logic [1:0]  quad;
  logic [30:0] xa;
  assign ph   = 32'(uniform_angle_i) << (32 - UNIFORM_BITS);
  assign quad = ph[31:30];
  assign xlo  = ph[29:0];
  assign xa   = quad[0] ? (31'h4000_0000 - 31'(xlo)) : 31'(xlo);

  logic [30:0] cx_q;
  logic        cneg_q [CosLat-1];
  logic signed [33:0] th_q;
  logic signed [33:0] t2_q;
  logic [31:0]        hmag_q [CosSteps];
  logic               hneg_q [CosSteps];
  logic signed [33:0] hacc_q [CosSteps];
  logic signed [33:0] ht2_q  [CosSteps-1];
  logic signed [33:0] t2p_q  [CosSteps-1];

  always_ff @(posedge clk_i) begin
    cx_q      <= xa;
    cneg_q[0] <= quad[0] ^ quad[1];
    th_q      <= 34'((63'(cx_q) * 63'(HalfPiQ30)) >> 30);
    t2_q      <= 34'((68'(th_q) * 68'(th_q)) >>> 30);
  end

  for (genvar k = 1; k < CosLat - 1; k++) begin : g_neg
    always_ff @(posedge clk_i) cneg_q[k] <= cneg_q[k-1];
  end

  // Horner step: acc = 1 - trunc(trunc(t2*acc / 2^30) / div), two stages.
  // First stage: |t2*acc| / 2^30 (t2 >= 0, so the sign is that of acc).
  // Second stage: divide by the series constant with a reciprocal multiply,
  // exact for any 32-bit magnitude, then subtract from one.
  for (genvar k = 0; k < CosSteps; k++) begin : g_hor
    localparam int unsigned DivK   = int'(CosDiv[k]);
    localparam int unsigned ShiftK = 32 + $clog2(DivK);
    localparam logic [32:0] RecipK =
      33'(((64'd1 << ShiftK) + 64'(DivK) - 64'd1) / 64'(DivK));
    logic signed [33:0] ain;
    logic signed [33:0] tin;
    logic        [33:0] amag;
    logic        [63:0] pr;
    logic        [65:0] qp;
    logic        [33:0] qk;
    if (k == 0) begin : g_f
      assign ain = Q30One;
      assign tin = t2_q;
    end else begin : g_n
      assign ain = hacc_q[k-1];
      assign tin = t2p_q[k-1];
    end
    assign amag = ain[33] ? 34'(-ain) : 34'(ain);
    assign pr   = 64'($unsigned(tin)) * 64'(amag);
    assign qp   = 66'(hmag_q[k]) * 66'(RecipK);
    assign qk   = 34'(qp >> ShiftK);
    always_ff @(posedge clk_i) begin
      hmag_q[k] <= 32'(pr >> 30);
      hneg_q[k] <= ain[33];
      hacc_q[k] <= hneg_q[k] ? (Q30One + $signed(qk)) : (Q30One - $signed(qk));
    end
    if (k < CosSteps - 1) begin : g_t2
      always_ff @(posedge clk_i) begin
        ht2_q[k] <= tin;
        t2p_q[k] <= ht2_q[k];
      end
    end
  end

  logic signed [33:0] cclamp;
  logic signed [33:0] cos_q;
  always_comb begin
    cclamp = hacc_q[CosSteps-1];
    if (cclamp > Q30One) cclamp = Q30One;
    if (cclamp < -Q30One) cclamp = -Q30One;
  end
  always_ff @(posedge clk_i) begin
    cos_q <= cneg_q[CosLat-2] ? -cclamp : cclamp;
  end

  logic signed [33:0] cdly_q [DlyN];
  always_ff @(posedge clk_i) cdly_q[0] <= cos_q;
  for (genvar k = 1; k < DlyN; k++) begin : g_dly
    always_ff @(posedge clk_i) cdly_q[k] <= cdly_q[k-1];
  end

  // ---------------- output: z = s*c, scale, mean, round, saturate ------
  logic        o_vld_q [5];
  logic signed [63:0] sc_q;
  logic signed [35:0] z_q;
  logic signed [55:0] zs_q;
  logic signed [57:0] v_q;
  logic signed [OutW-1:0] res_q;
  logic signed [57:0] vr;
  logic signed [33:0] fl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) o_vld_q[i] <= 1'b0;
    end else begin
      o_vld_q[0] <= sq_vld & ~sq_tag[0];
      for (int i = 1; i < 5; i++) o_vld_q[i] <= o_vld_q[i-1];
    end
  end

  assign vr = v_q + 58'sd8388608;
  assign fl = 34'(vr >>> 24);

  always_ff @(posedge clk_i) begin
    sc_q <= 64'($signed({1'b0, root})) * 64'(cdly_q[DlyN-1]);
    z_q  <= sc_q[63] ? -36'((-sc_q) >>> 30) : 36'(sc_q >>> 30);
    zs_q <= 56'(z_q) * 56'($signed({1'b0, std_q}));
    v_q  <= 58'(zs_q) + (58'(mean_q) <<< 24);
    if (fl > 34'(OutMax)) res_q <= OutMax;
    else if (fl < 34'(OutMin)) res_q <= OutMin;
    else res_q <= OutW'(fl);
  end

  assign done_o            = o_vld_q[4];
  assign gaussian_sample_o = res_q;

endmodule
